>>> sv/lfjc_pkg.sv
// ---------------------------------------------------------------------------
// lfjc_pkg
// Shared types and codes for the line follower junction counter.
// ---------------------------------------------------------------------------
package lfjc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FOLLOW = 2'd1,
        PH_FINISH = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        MV_STOP    = 2'd0,
        MV_ADVANCE = 2'd1,
        MV_RIGHT   = 2'd2,
        MV_LEFT    = 2'd3
    } motion_t;

    typedef enum logic [2:0] {
        CFG_TARGET_BLOCKS    = 3'd0,
        CFG_START_SPEED      = 3'd1,
        CFG_CENTER_BY_SENSOR = 3'd2,
        CFG_SPEED_FLOOR      = 3'd3,
        CFG_SPEED_STEP       = 3'd4,
        CFG_TURN_BOOST       = 3'd5,
        CFG_CREEP_LIMIT      = 3'd6,
        CFG_NUDGE_TIME       = 3'd7
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic {
        REQ_START  = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_t;

    typedef struct packed {
        logic [5:0]  target_blocks;
        logic [7:0]  start_speed;
        logic        center_by_sensor;
        logic [7:0]  speed_floor;
        logic [4:0]  speed_step;
        logic [5:0]  turn_boost;
        logic [15:0] creep_limit;
        logic [15:0] nudge_time;
    } cfg_t;

    typedef struct packed {
        req_t req_type;
        logic left_on;
        logic mid_on;
        logic right_on;
        logic estop;
    } item_t;

    typedef struct packed {
        motion_t    motion;
        logic [7:0] motor_speed;
        logic [5:0] junctions;
        logic       run_done;
        logic       aborted;
    } result_t;

endpackage

>>> sv/line_follow_junction_counter.sv
// ---------------------------------------------------------------------------
// line_follow_junction_counter
// Line follower junction counter: one motion command per start or sample item.
// ---------------------------------------------------------------------------
// Each accepted item gives exactly one result item. Items pass an input
// register, combinational decision logic and a result register, so one item
// is taken every cycle while the result side keeps up; the result reaches
// the master side from the result register and is held until taken. run_done is
// carried on m_tlast. Configuration writes are taken every cycle and should
// be made only while no item is in flight.
module line_follow_junction_counter
    import lfjc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // left_on, mid_on, right_on, estop
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // motion[1:0], motor_speed[7:0], junctions[5:0], aborted
    output logic                  m_tlast,   // run_done
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    lfjc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfjc_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (in_item_reg),
        .advance (advance),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.req_type <= req_t'(s_tuser);
            in_item_reg.left_on  <= s_tdata[0];
            in_item_reg.mid_on   <= s_tdata[1];
            in_item_reg.right_on <= s_tdata[2];
            in_item_reg.estop    <= s_tdata[3];
        end
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.run_done;
    assign m_tdata  = {7'd0, out_reg.aborted, out_reg.junctions,
                       out_reg.motor_speed, out_reg.motion};

endmodule

>>> sv/lfjc_cfg.sv
// ---------------------------------------------------------------------------
// lfjc_cfg
// Configuration register file, written by index.
// ---------------------------------------------------------------------------
module lfjc_cfg
    import lfjc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TARGET_BLOCKS:    cfg_next.target_blocks    = cfg_data[5:0];
                CFG_START_SPEED:      cfg_next.start_speed      = cfg_data[7:0];
                CFG_CENTER_BY_SENSOR: cfg_next.center_by_sensor = cfg_data[0];
                CFG_SPEED_FLOOR:      cfg_next.speed_floor      = cfg_data[7:0];
                CFG_SPEED_STEP:       cfg_next.speed_step       = cfg_data[4:0];
                CFG_TURN_BOOST:       cfg_next.turn_boost       = cfg_data[5:0];
                CFG_CREEP_LIMIT:      cfg_next.creep_limit      = cfg_data;
                CFG_NUDGE_TIME:       cfg_next.nudge_time       = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_blocks    <= 6'd5;
            cfg_reg.start_speed      <= 8'd60;
            cfg_reg.center_by_sensor <= 1'b0;
            cfg_reg.speed_floor      <= 8'd35;
            cfg_reg.speed_step       <= 5'd5;
            cfg_reg.turn_boost       <= 6'd10;
            cfg_reg.creep_limit      <= 16'd800;
            cfg_reg.nudge_time       <= 16'd110;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/lfjc_step.sv
// ---------------------------------------------------------------------------
// lfjc_step
// Run state and per-item decision logic; state moves when an item advances.
// ---------------------------------------------------------------------------
module lfjc_step
    import lfjc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    advance,
    output result_t result
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  count_reg, count_next;
    logic        onj_reg, onj_next;
    logic [15:0] ticks_reg, ticks_next;
    motion_t     last_motion_reg;
    logic [7:0]  last_speed_reg;

    logic [2:0]  pat;
    logic        is_start, es;
    logic        follow, finish;
    logic        count_ge, count_eq;
    logic [5:0]  count_inc;
    logic        new_junction;
    logic        enter, lim_zero;
    logic        follow_over, follow_estop;
    logic        creep_end_ok, creep_abort, nudge_end;
    logic        end_ok, end_abort;
    logic [15:0] ticks_inc;
    logic [10:0] prod;
    logic [11:0] diff;
    logic [7:0]  spd;
    logic [8:0]  boost_sum;
    logic [7:0]  spd_boost;

    assign pat      = {item.left_on, item.mid_on, item.right_on};
    assign is_start = (item.req_type == REQ_START);
    assign es       = item.estop;
    assign follow   = !is_start && (phase_reg == PH_FOLLOW);
    assign finish   = !is_start && (phase_reg == PH_FINISH);

    assign count_ge     = (count_reg >= cfg.target_blocks);
    assign count_eq     = (count_reg == cfg.target_blocks);
    assign count_inc    = count_reg + 6'd1;
    assign new_junction = follow && !count_ge && (pat == 3'b111) && !onj_reg;
    assign lim_zero     = cfg.center_by_sensor ? (cfg.creep_limit == 16'd0)
                                               : (cfg.nudge_time == 16'd0);

    assign enter        = follow && (count_ge ? count_eq
                                              : (new_junction &&
                                                 (count_inc == cfg.target_blocks)));
    assign follow_over  = follow && count_ge && !count_eq;
    assign follow_estop = follow && !count_ge && !enter && es;

    assign creep_end_ok = finish && cfg.center_by_sensor &&
                          ((pat == 3'b010) || (!es && (ticks_reg >= cfg.creep_limit)));
    assign creep_abort  = finish && cfg.center_by_sensor && (pat != 3'b010) && es;
    assign ticks_inc    = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
    assign nudge_end    = finish && !cfg.center_by_sensor && (ticks_inc >= cfg.nudge_time);

    assign end_ok    = follow_over || (enter && lim_zero) || creep_end_ok || nudge_end;
    assign end_abort = follow_estop || creep_abort;

    // speed before this item's junction: start minus count times step, floored
    assign prod = {5'd0, count_reg} * {6'd0, cfg.speed_step};
    assign diff = {4'd0, cfg.start_speed} - {1'b0, prod};
    always_comb
    begin
        if (diff[11] || (diff[7:0] < cfg.speed_floor))
            spd = cfg.speed_floor;
        else
            spd = diff[7:0];
    end
    assign boost_sum = {1'b0, spd} + {3'd0, cfg.turn_boost};
    assign spd_boost = boost_sum[8] ? 8'hFF : boost_sum[7:0];

    // next state
    always_comb
    begin
        priority if (is_start)
            phase_next = PH_FOLLOW;
        else if (end_ok || end_abort)
            phase_next = PH_IDLE;
        else if (enter)
            phase_next = PH_FINISH;
        else
        begin
            unique case (phase_reg)
                PH_FOLLOW: phase_next = PH_FOLLOW;
                PH_FINISH: phase_next = PH_FINISH;
                default:   phase_next = PH_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        result.junctions = count_next;
        result.run_done  = 1'b0;
        result.aborted   = 1'b0;
        result.motion    = MV_STOP;
        result.motor_speed = 8'd0;
        priority if (is_start)
        begin
            result.motion = MV_STOP;
        end
        else if (end_ok || end_abort)
        begin
            result.run_done = 1'b1;
            result.aborted  = end_abort;
        end
        else if (enter || finish)
        begin
            result.motion      = MV_ADVANCE;
            result.motor_speed = cfg.speed_floor;
        end
        else if (follow)
        begin
            unique case (pat)
                3'b111, 3'b010, 3'b000:
                begin
                    result.motion      = MV_ADVANCE;
                    result.motor_speed = spd;
                end
                3'b001, 3'b011:
                begin
                    result.motion      = MV_RIGHT;
                    result.motor_speed = spd_boost;
                end
                3'b100, 3'b110:
                begin
                    result.motion      = MV_LEFT;
                    result.motor_speed = spd_boost;
                end
                default:
                begin
                    result.motion      = last_motion_reg;
                    result.motor_speed = last_speed_reg;
                end
            endcase
        end
        if (result.motion == MV_STOP)
            result.motor_speed = 8'd0;
    end

    // run counters
    always_comb
    begin
        count_next = count_reg;
        onj_next   = onj_reg;
        ticks_next = ticks_reg;
        priority if (is_start)
        begin
            count_next = 6'd0;
            onj_next   = 1'b1;
            ticks_next = 16'd0;
        end
        else if (follow && !count_ge)
        begin
            if (new_junction)
                count_next = count_inc;
            if (pat == 3'b111)
                onj_next = 1'b1;
            else if (pat != 3'b101)
                onj_next = 1'b0;
            if (enter)
                ticks_next = 16'd0;
        end
        else if (enter)
        begin
            ticks_next = 16'd0;
        end
        else if (finish)
        begin
            if (!cfg.center_by_sensor)
                ticks_next = ticks_inc;
            else if (!creep_end_ok && !creep_abort)
                ticks_next = ticks_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            count_reg       <= 6'd0;
            onj_reg         <= 1'b1;
            ticks_reg       <= 16'd0;
            last_motion_reg <= MV_STOP;
            last_speed_reg  <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            onj_reg         <= onj_next;
            ticks_reg       <= ticks_next;
            last_motion_reg <= result.motion;
            last_speed_reg  <= result.motor_speed;
        end
    end

endmodule
